>>> sv/ctf_pkg.sv
// Shared types and character constants for the console token FIFO.
`default_nettype none

package ctf_pkg;

   localparam int TALLY_W = 9;
   localparam logic [TALLY_W-1:0] TALLY_MAX = '1;

   localparam logic [7:0] CHAR_NUL   = 8'h00;
   localparam logic [7:0] CHAR_LF    = 8'h0A;
   localparam logic [7:0] CHAR_CR    = 8'h0D;
   localparam logic [7:0] CHAR_SPACE = 8'h20;

   localparam logic FUNC_PUSH = 1'b0;
   localparam logic FUNC_POP  = 1'b1;

   // Commands from the sequencer to the pointer unit.
   typedef struct packed {
      logic push;
      logic pop;
   } ptr_cmd_type;

   // Status from the pointer unit back to the sequencer.
   typedef struct packed {
      logic empty;
      logic full;
   } ptr_stat_type;

endpackage

`default_nettype wire

>>> sv/ctf_if.sv
// Valid/ready channel interfaces for the request and response sides.
`default_nettype none

interface ctf_req_if;
   logic       valid;
   logic       ready;
   logic       func;
   logic [7:0] rx_byte;

   modport source (output valid, output func, output rx_byte, input ready);
   modport sink   (input valid, input func, input rx_byte, output ready);
endinterface

interface ctf_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] read_byte;
   logic       was_empty;
   logic       overflow;
   logic [8:0] words_held;
   logic [8:0] lines_held;

   modport source (output valid, output read_byte, output was_empty, output overflow,
                   output words_held, output lines_held, input ready);
   modport sink   (input valid, input read_byte, input was_empty, input overflow,
                   input words_held, input lines_held, output ready);
endinterface

`default_nettype wire

>>> sv/ctf_ram.sv
// Generic single-write, single-read RAM with a registered read port.
`default_nettype none

module ctf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  wire logic              clock,
   input  wire logic              we,
   input  wire logic [ADDR_W-1:0] waddr,
   input  wire logic [WIDTH-1:0]  wdata,
   input  wire logic [ADDR_W-1:0] raddr,
   output logic      [WIDTH-1:0]  rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

>>> sv/ctf_ptrs.sv
// Head, tail and fill bookkeeping for the byte store.
`default_nettype none

module ctf_ptrs #(
   parameter int DEPTH = 256,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire ctf_pkg::ptr_cmd_type      cmd,
   output logic         [ADDR_W-1:0]      wr_addr,
   output logic         [ADDR_W-1:0]      rd_addr,
   output ctf_pkg::ptr_stat_type          stat
);
   import ctf_pkg::*;

   localparam int FILL_W = $clog2(DEPTH + 1);
   localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(DEPTH - 1);
   localparam logic [FILL_W-1:0] FULL_FILL = FILL_W'(DEPTH);

   logic [ADDR_W-1:0] head_ff, head_in;
   logic [ADDR_W-1:0] tail_ff, tail_in;
   logic [FILL_W-1:0] fill_ff, fill_in;

   always_comb begin
      head_in = head_ff;
      tail_in = tail_ff;
      fill_in = fill_ff;
      // The sequencer never pushes and pops in the same cycle.
      if (cmd.push) begin
         tail_in = (tail_ff == LAST_ADDR) ? '0 : tail_ff + 1'b1;
         fill_in = fill_ff + 1'b1;
      end else if (cmd.pop) begin
         head_in = (head_ff == LAST_ADDR) ? '0 : head_ff + 1'b1;
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff <= '0;
         tail_ff <= '0;
         fill_ff <= '0;
      end else begin
         head_ff <= head_in;
         tail_ff <= tail_in;
         fill_ff <= fill_in;
      end
   end

   assign wr_addr    = tail_ff;
   assign rd_addr    = head_ff;
   assign stat.empty = (fill_ff == '0);
   assign stat.full  = (fill_ff == FULL_FILL);

endmodule

`default_nettype wire

>>> sv/console_token_fifo_core.sv
// Top level of the console token FIFO: sequencer, tallies and response register.
//
//   channel   dir  handshake      payload
//   req_if    in   valid/ready    func, rx_byte
//   rsp_if    out  valid/ready    read_byte, was_empty, overflow, words_held, lines_held
//
// A push of a space, a terminator or a character not preceded by a space is handled in
// the idle state alone; a character that follows a space also passes through the character
// state while there is room for the space, because the byte store has a single write port
// and the space goes in first. A pop of a non-empty FIFO passes through the read-wait state
// for the registered read of the byte store; a pop of an empty FIFO does not.
// Reset is synchronous and needs no clearing pass; the store is read only where written.
// A request is taken only while the response register is empty or being drained.
`default_nettype none

module console_token_fifo_core #(
   parameter int FIFO_DEPTH = 256
) (
   input  wire logic clock,
   input  wire logic reset,
   ctf_req_if.sink   req_if,
   ctf_rsp_if.source rsp_if
);
   import ctf_pkg::*;

   localparam int ADDR_W = $clog2(FIFO_DEPTH);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CHAR,
      ST_POP
   } state_type;

   typedef enum logic [1:0] {
      CLASS_NUL,
      CLASS_SPACE,
      CLASS_OTHER
   } class_type;

   function automatic logic [TALLY_W-1:0] tally_up(input logic [TALLY_W-1:0] t);
      return (t < TALLY_MAX) ? t + 1'b1 : TALLY_MAX;
   endfunction

   function automatic logic [TALLY_W-1:0] tally_down(input logic [TALLY_W-1:0] t);
      return (t != '0) ? t - 1'b1 : '0;
   endfunction

   state_type          state_ff, state_in;
   class_type          prev_ff, prev_in;
   logic [TALLY_W-1:0] words_ff, words_in;
   logic [TALLY_W-1:0] lines_ff, lines_in;
   logic [7:0]         char_ff, char_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [7:0]         rsp_byte_ff, rsp_byte_in;
   logic               rsp_empty_ff, rsp_empty_in;
   logic               rsp_ovf_ff, rsp_ovf_in;
   logic [TALLY_W-1:0] rsp_words_ff, rsp_words_in;
   logic [TALLY_W-1:0] rsp_lines_ff, rsp_lines_in;

   ptr_cmd_type        cmd;
   ptr_stat_type       stat;
   logic [ADDR_W-1:0]  wr_addr;
   logic [ADDR_W-1:0]  rd_addr;
   logic               ram_we;
   logic [7:0]         ram_wdata;
   logic [7:0]         ram_rdata;

   logic               req_ready;
   logic               accept;
   logic               load;
   logic [7:0]         load_byte;
   logic               load_empty;
   logic               load_ovf;
   logic               is_term;

   ctf_ptrs #(.DEPTH(FIFO_DEPTH)) u_ptrs (
      .clock   (clock),
      .reset   (reset),
      .cmd     (cmd),
      .wr_addr (wr_addr),
      .rd_addr (rd_addr),
      .stat    (stat)
   );

   ctf_ram #(.WIDTH(8), .DEPTH(FIFO_DEPTH)) u_store (
      .clock (clock),
      .we    (ram_we),
      .waddr (wr_addr),
      .wdata (ram_wdata),
      .raddr (rd_addr),
      .rdata (ram_rdata)
   );

   assign req_ready = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_if.ready);
   assign accept    = req_if.valid && req_ready;
   assign is_term   = (req_if.rx_byte == CHAR_CR) || (req_if.rx_byte == CHAR_LF) ||
                      (req_if.rx_byte == CHAR_NUL);

   always_comb begin
      state_in   = state_ff;
      prev_in    = prev_ff;
      words_in   = words_ff;
      lines_in   = lines_ff;
      char_in    = char_ff;
      cmd        = '0;
      ram_we     = 1'b0;
      ram_wdata  = CHAR_NUL;
      load       = 1'b0;
      load_byte  = CHAR_NUL;
      load_empty = 1'b0;
      load_ovf   = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_if.func == FUNC_POP) begin
                  if (!stat.empty) begin
                     // The store registers the head byte at this edge for the read-wait state.
                     cmd.pop  = 1'b1;
                     state_in = ST_POP;
                  end else begin
                     // An empty pop returns zero, which counts as a terminator.
                     words_in   = tally_down(words_ff);
                     lines_in   = tally_down(lines_ff);
                     load       = 1'b1;
                     load_empty = 1'b1;
                  end
               end else if (req_if.rx_byte == CHAR_SPACE) begin
                  if (prev_ff != CLASS_NUL) begin
                     prev_in = CLASS_SPACE;
                  end
                  load = 1'b1;
               end else if (is_term) begin
                  if (prev_ff != CLASS_NUL) begin
                     if (!stat.full) begin
                        ram_we    = 1'b1;
                        ram_wdata = CHAR_NUL;
                        cmd.push  = 1'b1;
                        words_in  = tally_up(words_ff);
                        lines_in  = tally_up(lines_ff);
                     end else begin
                        load_ovf = 1'b1;
                     end
                  end
                  prev_in = CLASS_NUL;
                  load    = 1'b1;
               end else begin
                  prev_in = CLASS_OTHER;
                  if ((prev_ff == CLASS_SPACE) && !stat.full) begin
                     // The separating space goes in now, the character next cycle.
                     ram_we    = 1'b1;
                     ram_wdata = CHAR_SPACE;
                     cmd.push  = 1'b1;
                     words_in  = tally_up(words_ff);
                     char_in   = req_if.rx_byte;
                     state_in  = ST_CHAR;
                  end else begin
                     if (!stat.full) begin
                        ram_we    = 1'b1;
                        ram_wdata = req_if.rx_byte;
                        cmd.push  = 1'b1;
                     end else begin
                        load_ovf = 1'b1;
                     end
                     load = 1'b1;
                  end
               end
            end
         end
         ST_CHAR: begin
            if (!stat.full) begin
               ram_we    = 1'b1;
               ram_wdata = char_ff;
               cmd.push  = 1'b1;
            end else begin
               load_ovf = 1'b1;
            end
            load     = 1'b1;
            state_in = ST_IDLE;
         end
         ST_POP: begin
            load_byte = ram_rdata;
            if (ram_rdata == CHAR_NUL) begin
               words_in = tally_down(words_ff);
               lines_in = tally_down(lines_ff);
            end else if (ram_rdata == CHAR_SPACE) begin
               words_in = tally_down(words_ff);
            end
            load     = 1'b1;
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Response register: a new result only lands when the register is free or draining.
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_if.ready;
      rsp_byte_in  = rsp_byte_ff;
      rsp_empty_in = rsp_empty_ff;
      rsp_ovf_in   = rsp_ovf_ff;
      rsp_words_in = rsp_words_ff;
      rsp_lines_in = rsp_lines_ff;
      if (load) begin
         rsp_valid_in = 1'b1;
         rsp_byte_in  = load_byte;
         rsp_empty_in = load_empty;
         rsp_ovf_in   = load_ovf;
         rsp_words_in = words_in;
         rsp_lines_in = lines_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         prev_ff      <= CLASS_NUL;
         words_ff     <= '0;
         lines_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         prev_ff      <= prev_in;
         words_ff     <= words_in;
         lines_ff     <= lines_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      char_ff      <= char_in;
      rsp_byte_ff  <= rsp_byte_in;
      rsp_empty_ff <= rsp_empty_in;
      rsp_ovf_ff   <= rsp_ovf_in;
      rsp_words_ff <= rsp_words_in;
      rsp_lines_ff <= rsp_lines_in;
   end

   assign req_if.ready      = req_ready;
   assign rsp_if.valid      = rsp_valid_ff;
   assign rsp_if.read_byte  = rsp_byte_ff;
   assign rsp_if.was_empty  = rsp_empty_ff;
   assign rsp_if.overflow   = rsp_ovf_ff;
   assign rsp_if.words_held = rsp_words_ff;
   assign rsp_if.lines_held = rsp_lines_ff;

   // The read-wait state is entered only from an accepted pop of a non-empty FIFO.
   a_pop_origin: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_POP) |-> $past(accept && (req_if.func == FUNC_POP) && !stat.empty))
      else $error("read-wait state without a preceding pop");

   // The byte store is never written while full.
   a_no_write_full: assert property (@(posedge clock) disable iff (reset)
      ram_we |-> !stat.full)
      else $error("write to a full byte store");

   // A result is never produced while an older one is still held.
   a_no_clobber: assert property (@(posedge clock) disable iff (reset)
      load |-> (!rsp_valid_ff || rsp_if.ready))
      else $error("response register overwritten");

   // An empty pop and a lost byte cannot belong to the same transaction.
   a_flag_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_empty_ff && rsp_ovf_ff))
      else $error("was_empty and overflow both set");

endmodule

`default_nettype wire
